// File: src/attitude_quaternion_integrator_core_assert.svh
// Assertion macros for the attitude quaternion integrator.
// Used by the port checker; needs clk and rst_n in scope.
`ifndef ATTITUDE_QUATERNION_INTEGRATOR_CORE_ASSERT_SVH
`define ATTITUDE_QUATERNION_INTEGRATOR_CORE_ASSERT_SVH

// same-cycle implication
`define AQI_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("aqi check failed");

// next-cycle implication
`define AQI_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("aqi check failed");

`endif

// File: src/aqi_pkg.sv
// Shared types, constants and table functions of the attitude integrator.
// No dependencies; used by aqi_ctrl, aqi_dp and the top level.
`default_nettype none

package aqi_pkg;

    localparam int CORDIC_ITERATIONS_DEF = 32;

    localparam logic [31:0] TIME_STEP_RESET = 32'd167772;
    localparam logic [31:0] ONE_Q30         = 32'h4000_0000;
    localparam logic [31:0] PI_Q30          = 32'd3373259426;
    localparam logic [31:0] HALF_PI_Q30     = 32'd1686629713;
    localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic [63:0] SQRT_TOP_BIT    = 64'h4000_0000_0000_0000;
    localparam logic [5:0]  SQRT_LAST       = 6'd31;
    localparam logic [5:0]  DIV_LAST        = 6'd31;

    // register index (byte address / 4)
    localparam logic REG_TIME_STEP = 1'b0;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_CAPTURE,
        OP_MUL_RSQ,
        OP_ACC,
        OP_SQRT_INIT,
        OP_SQRT_STEP,
        OP_MUL_H,
        OP_H_SET,
        OP_CORDIC,
        OP_D0,
        OP_D_IDENT,
        OP_MUL_RY,
        OP_DIV_INIT_R,
        OP_NDIV_INIT,
        OP_DIV_STEP,
        OP_D_STORE,
        OP_QMUL,
        OP_QACC,
        OP_MAX,
        OP_SHR,
        OP_SHL,
        OP_SCALE,
        OP_MUL_SSQ,
        OP_IDENT,
        OP_NSTORE,
        OP_OUT
    } op_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_RSQ,
        S_RACC,
        S_SQ_INIT,
        S_SQ_STEP,
        S_MAG_CHK,
        S_H_SET,
        S_CORDIC,
        S_D0,
        S_RY_MUL,
        S_DIV_INIT,
        S_DIV_STEP,
        S_D_STORE,
        S_QMUL,
        S_QACC,
        S_MAX,
        S_SHIFT,
        S_SCALE,
        S_SSQ,
        S_SACC,
        S_NSTORE,
        S_FINISH
    } state_t;

    typedef struct packed {
        op_t        op;
        logic [3:0] idx;
        logic [5:0] cnt;
    } cmd_t;

    typedef struct packed {
        logic mag_zero;
        logic m_zero;
        logic m_high;
        logic m_low;
    } sts_t;

    // CORDIC arctangent step, Q2.30
    function automatic logic signed [33:0] atan_step(input logic [5:0] i);
        logic signed [33:0] t;
        unique case (i)
            6'd0:    t = 34'sd843314857;
            6'd1:    t = 34'sd497837829;
            6'd2:    t = 34'sd263043837;
            6'd3:    t = 34'sd133525159;
            6'd4:    t = 34'sd67021687;
            6'd5:    t = 34'sd33543516;
            6'd6:    t = 34'sd16775851;
            6'd7:    t = 34'sd8388437;
            6'd8:    t = 34'sd4194283;
            6'd9:    t = 34'sd2097149;
            default: t = (i <= 6'd30) ? (34'sd1 <<< (6'd30 - i)) : 34'sd0;
        endcase
        return t;
    endfunction

    // sign of term k = 4*component + attitude index in attitude * delta
    function automatic logic qterm_neg(input logic [3:0] k);
        return (k == 4'd1) || (k == 4'd2) || (k == 4'd3) ||
               (k == 4'd7) || (k == 4'd9) || (k == 4'd14);
    endfunction

endpackage

`default_nettype wire

// File: src/aqi_ctrl.sv
// Sequencer of the attitude integrator: one item at a time, step by step.
// Depends on aqi_pkg; drives aqi_dp through a command struct.
`default_nettype none

module aqi_ctrl #(
    parameter int CORDIC_ITERATIONS = aqi_pkg::CORDIC_ITERATIONS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  logic          s_axis_tuser,
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    output aqi_pkg::cmd_t cmd,
    input  aqi_pkg::sts_t sts
);

    localparam logic [5:0] CORDIC_LAST = 6'(CORDIC_ITERATIONS - 1);

    aqi_pkg::state_t state_reg, state_next;
    logic [3:0] idx_reg, idx_next;
    logic [5:0] cnt_reg, cnt_next;
    logic       norm_reg, norm_next;
    logic       out_valid_reg, out_valid_next;

    assign s_axis_tready = (state_reg == aqi_pkg::S_IDLE);
    assign m_axis_tvalid = out_valid_reg;

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= aqi_pkg::S_IDLE;
            idx_reg       <= '0;
            cnt_reg       <= '0;
            norm_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            cnt_reg       <= cnt_next;
            norm_reg      <= norm_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        cnt_next       = cnt_reg;
        norm_next      = norm_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        cmd.op         = aqi_pkg::OP_NONE;
        cmd.idx        = idx_reg;
        cmd.cnt        = cnt_reg;
        unique case (state_reg)
            aqi_pkg::S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    cmd.op     = aqi_pkg::OP_CAPTURE;
                    idx_next   = '0;
                    cnt_next   = '0;
                    norm_next  = 1'b0;
                    state_next = s_axis_tuser ? aqi_pkg::S_MAX : aqi_pkg::S_RSQ;
                end
            end
            aqi_pkg::S_RSQ:
            begin
                cmd.op     = aqi_pkg::OP_MUL_RSQ;
                state_next = aqi_pkg::S_RACC;
            end
            aqi_pkg::S_RACC:
            begin
                cmd.op = aqi_pkg::OP_ACC;
                if (idx_reg == 4'd2)
                begin
                    idx_next   = '0;
                    state_next = aqi_pkg::S_SQ_INIT;
                end
                else
                begin
                    idx_next   = idx_reg + 4'd1;
                    state_next = aqi_pkg::S_RSQ;
                end
            end
            aqi_pkg::S_SQ_INIT:
            begin
                cmd.op     = aqi_pkg::OP_SQRT_INIT;
                cnt_next   = '0;
                state_next = aqi_pkg::S_SQ_STEP;
            end
            aqi_pkg::S_SQ_STEP:
            begin
                cmd.op = aqi_pkg::OP_SQRT_STEP;
                if (cnt_reg == aqi_pkg::SQRT_LAST)
                begin
                    cnt_next   = '0;
                    idx_next   = '0;
                    state_next = norm_reg ? aqi_pkg::S_DIV_INIT : aqi_pkg::S_MAG_CHK;
                end
                else
                begin
                    cnt_next = cnt_reg + 6'd1;
                end
            end
            aqi_pkg::S_MAG_CHK:
            begin
                if (sts.mag_zero)
                begin
                    cmd.op     = aqi_pkg::OP_D_IDENT;
                    idx_next   = '0;
                    state_next = aqi_pkg::S_QMUL;
                end
                else
                begin
                    cmd.op     = aqi_pkg::OP_MUL_H;
                    state_next = aqi_pkg::S_H_SET;
                end
            end
            aqi_pkg::S_H_SET:
            begin
                cmd.op     = aqi_pkg::OP_H_SET;
                cnt_next   = '0;
                state_next = aqi_pkg::S_CORDIC;
            end
            aqi_pkg::S_CORDIC:
            begin
                cmd.op = aqi_pkg::OP_CORDIC;
                if (cnt_reg == CORDIC_LAST)
                    state_next = aqi_pkg::S_D0;
                else
                    cnt_next = cnt_reg + 6'd1;
            end
            aqi_pkg::S_D0:
            begin
                cmd.op     = aqi_pkg::OP_D0;
                idx_next   = '0;
                state_next = aqi_pkg::S_RY_MUL;
            end
            aqi_pkg::S_RY_MUL:
            begin
                cmd.op     = aqi_pkg::OP_MUL_RY;
                state_next = aqi_pkg::S_DIV_INIT;
            end
            aqi_pkg::S_DIV_INIT:
            begin
                cmd.op     = norm_reg ? aqi_pkg::OP_NDIV_INIT : aqi_pkg::OP_DIV_INIT_R;
                cnt_next   = '0;
                state_next = aqi_pkg::S_DIV_STEP;
            end
            aqi_pkg::S_DIV_STEP:
            begin
                cmd.op = aqi_pkg::OP_DIV_STEP;
                if (cnt_reg == aqi_pkg::DIV_LAST)
                    state_next = norm_reg ? aqi_pkg::S_NSTORE : aqi_pkg::S_D_STORE;
                else
                    cnt_next = cnt_reg + 6'd1;
            end
            aqi_pkg::S_D_STORE:
            begin
                cmd.op = aqi_pkg::OP_D_STORE;
                if (idx_reg == 4'd2)
                begin
                    idx_next   = '0;
                    state_next = aqi_pkg::S_QMUL;
                end
                else
                begin
                    idx_next   = idx_reg + 4'd1;
                    state_next = aqi_pkg::S_RY_MUL;
                end
            end
            aqi_pkg::S_QMUL:
            begin
                cmd.op     = aqi_pkg::OP_QMUL;
                state_next = aqi_pkg::S_QACC;
            end
            aqi_pkg::S_QACC:
            begin
                cmd.op = aqi_pkg::OP_QACC;
                if (idx_reg == 4'd15)
                begin
                    idx_next   = '0;
                    state_next = aqi_pkg::S_MAX;
                end
                else
                begin
                    idx_next   = idx_reg + 4'd1;
                    state_next = aqi_pkg::S_QMUL;
                end
            end
            aqi_pkg::S_MAX:
            begin
                cmd.op = aqi_pkg::OP_MAX;
                if (idx_reg == 4'd3)
                    state_next = aqi_pkg::S_SHIFT;
                else
                    idx_next = idx_reg + 4'd1;
            end
            aqi_pkg::S_SHIFT:
            begin
                priority if (sts.m_zero)
                begin
                    cmd.op     = aqi_pkg::OP_IDENT;
                    state_next = aqi_pkg::S_FINISH;
                end
                else if (sts.m_high)
                    cmd.op = aqi_pkg::OP_SHR;
                else if (sts.m_low)
                    cmd.op = aqi_pkg::OP_SHL;
                else
                begin
                    idx_next   = '0;
                    state_next = aqi_pkg::S_SCALE;
                end
            end
            aqi_pkg::S_SCALE:
            begin
                cmd.op = aqi_pkg::OP_SCALE;
                if (idx_reg == 4'd3)
                begin
                    idx_next   = '0;
                    state_next = aqi_pkg::S_SSQ;
                end
                else
                    idx_next = idx_reg + 4'd1;
            end
            aqi_pkg::S_SSQ:
            begin
                cmd.op     = aqi_pkg::OP_MUL_SSQ;
                state_next = aqi_pkg::S_SACC;
            end
            aqi_pkg::S_SACC:
            begin
                cmd.op = aqi_pkg::OP_ACC;
                if (idx_reg == 4'd3)
                begin
                    idx_next   = '0;
                    norm_next  = 1'b1;
                    state_next = aqi_pkg::S_SQ_INIT;
                end
                else
                begin
                    idx_next   = idx_reg + 4'd1;
                    state_next = aqi_pkg::S_SSQ;
                end
            end
            aqi_pkg::S_NSTORE:
            begin
                cmd.op = aqi_pkg::OP_NSTORE;
                if (idx_reg == 4'd3)
                    state_next = aqi_pkg::S_FINISH;
                else
                begin
                    idx_next   = idx_reg + 4'd1;
                    state_next = aqi_pkg::S_DIV_INIT;
                end
            end
            aqi_pkg::S_FINISH:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    cmd.op         = aqi_pkg::OP_OUT;
                    out_valid_next = 1'b1;
                    state_next     = aqi_pkg::S_IDLE;
                end
            end
            default:
                state_next = aqi_pkg::S_IDLE;
        endcase
    end

endmodule

`default_nettype wire

// File: src/aqi_dp.sv
// Datapath of the attitude integrator: shared multiplier, root, divider, CORDIC.
// Depends on aqi_pkg; executes one command of aqi_ctrl per cycle.
`default_nettype none

module aqi_dp (
    input  logic          clk,
    input  logic          rst_n,
    input  aqi_pkg::cmd_t cmd,
    output aqi_pkg::sts_t sts,
    input  logic [31:0]   time_step,
    input  logic [31:0]   rate_x,
    input  logic [31:0]   rate_y,
    input  logic [31:0]   rate_z,
    input  logic [31:0]   load_w,
    input  logic [31:0]   load_x,
    input  logic [31:0]   load_y,
    input  logic [31:0]   load_z,
    output logic [31:0]   att_w,
    output logic [31:0]   att_x,
    output logic [31:0]   att_y,
    output logic [31:0]   att_z
);

    logic signed [31:0] rx_reg, ry_reg, rz_reg, rx_next, ry_next, rz_next;
    logic signed [63:0] prod_reg, prod_next;
    logic [63:0]        sum_reg, sum_next;
    logic [63:0]        sx_reg, sx_next;
    logic [63:0]        root_reg, root_next;
    logic               flip_reg, flip_next;
    logic signed [33:0] cx_reg, cy_reg, cz_reg, cx_next, cy_next, cz_next;
    logic signed [33:0] d_reg [4];
    logic signed [33:0] d_next [4];
    logic signed [63:0] c_reg [4];
    logic signed [63:0] c_next [4];
    logic [63:0]        m_reg, m_next;
    logic [5:0]         rsh_reg, rsh_next, lsh_reg, lsh_next;
    logic signed [31:0] s_reg [4];
    logic signed [31:0] s_next [4];
    logic [32:0]        rem_reg, rem_next;
    logic [31:0]        quo_reg, quo_next;
    logic               neg_reg, neg_next;
    logic signed [31:0] att_reg [4];
    logic signed [31:0] att_next [4];
    logic [31:0]        out_reg [4];
    logic [31:0]        out_next [4];

    logic [1:0]         sel;
    logic signed [31:0] rsel;
    logic signed [33:0] ma, mb;
    logic signed [67:0] prod_full;
    logic [63:0]        sq_b, sq_t;
    logic [44:0]        h_raw;
    logic [31:0]        h_sat, h_fin;
    logic signed [33:0] cdx, cdy, cat;
    logic [63:0]        prod_mag;
    logic signed [31:0] s_sel;
    logic [31:0]        s_mag;
    logic [63:0]        nd_div;
    logic [32:0]        div_sh, div_d;
    logic [31:0]        q_clamp;
    logic signed [63:0] c_sel, c_scaled, acc_base;
    logic [63:0]        c_mag;
    logic signed [33:0] dq;

    assign sel = cmd.idx[1:0];

    // status to the sequencer
    assign sts.mag_zero = (root_reg == '0);
    assign sts.m_zero   = (m_reg == '0);
    assign sts.m_high   = |m_reg[63:30];
    assign sts.m_low    = (m_reg[63:29] == '0);

    // rate component select
    always_comb
    begin
        unique case (sel)
            2'd0:    rsel = rx_reg;
            2'd1:    rsel = ry_reg;
            default: rsel = rz_reg;
        endcase
    end

    // shared multiplier operands
    always_comb
    begin
        unique case (cmd.op)
            aqi_pkg::OP_MUL_RSQ:
            begin
                ma = 34'(rsel);
                mb = 34'(rsel);
            end
            aqi_pkg::OP_MUL_H:
            begin
                ma = $signed({2'b00, root_reg[31:0]});
                mb = $signed({2'b00, time_step});
            end
            aqi_pkg::OP_MUL_RY:
            begin
                ma = 34'(rsel);
                mb = cy_reg;
            end
            aqi_pkg::OP_QMUL:
            begin
                ma = 34'(att_reg[sel]);
                mb = d_reg[sel ^ cmd.idx[3:2]];
            end
            aqi_pkg::OP_MUL_SSQ:
            begin
                ma = 34'(s_reg[sel]);
                mb = 34'(s_reg[sel]);
            end
            default:
            begin
                ma = '0;
                mb = '0;
            end
        endcase
    end

    assign prod_full = ma * mb;

    // bit-pair square root step
    assign sq_b = aqi_pkg::SQRT_TOP_BIT >> {cmd.cnt, 1'b0};
    assign sq_t = root_reg + sq_b;

    // half angle, saturated and folded into the first quadrant
    assign h_raw = prod_reg[63:19];
    assign h_sat = (h_raw > {13'd0, aqi_pkg::PI_Q30}) ? aqi_pkg::PI_Q30 : h_raw[31:0];
    assign h_fin = (h_sat > aqi_pkg::HALF_PI_Q30) ? (aqi_pkg::PI_Q30 - h_sat) : h_sat;

    // CORDIC terms
    assign cdx = cy_reg >>> cmd.cnt;
    assign cdy = cx_reg >>> cmd.cnt;
    assign cat = aqi_pkg::atan_step(cmd.cnt);

    // divider operands
    assign prod_mag = prod_reg[63] ? 64'(-prod_reg) : 64'(prod_reg);
    assign s_sel    = s_reg[sel];
    assign s_mag    = s_sel[31] ? 32'(-s_sel) : 32'(s_sel);
    assign nd_div   = ({32'd0, s_mag} << 30) + {1'b0, root_reg[63:1]};
    assign div_sh   = {rem_reg[31:0], quo_reg[31]};
    assign div_d    = {1'b0, root_reg[31:0]};
    assign q_clamp  = (quo_reg > aqi_pkg::ONE_Q30) ? aqi_pkg::ONE_Q30 : quo_reg;
    assign dq       = $signed({2'b00, quo_reg});

    // normalization helpers
    assign c_sel    = c_reg[sel];
    assign c_mag    = c_sel[63] ? 64'(-c_sel) : 64'(c_sel);
    assign c_scaled = (rsh_reg != '0) ? (c_sel >>> rsh_reg) : (c_sel <<< lsh_reg);
    assign acc_base = (sel == 2'd0) ? 64'sd0 : c_reg[cmd.idx[3:2]];

    // next values per command
    always_comb
    begin
        rx_next   = rx_reg;
        ry_next   = ry_reg;
        rz_next   = rz_reg;
        prod_next = prod_reg;
        sum_next  = sum_reg;
        sx_next   = sx_reg;
        root_next = root_reg;
        flip_next = flip_reg;
        cx_next   = cx_reg;
        cy_next   = cy_reg;
        cz_next   = cz_reg;
        m_next    = m_reg;
        rsh_next  = rsh_reg;
        lsh_next  = lsh_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        neg_next  = neg_reg;
        for (int i = 0; i < 4; i++)
        begin
            d_next[i]   = d_reg[i];
            c_next[i]   = c_reg[i];
            s_next[i]   = s_reg[i];
            att_next[i] = att_reg[i];
            out_next[i] = out_reg[i];
        end
        unique case (cmd.op)
            aqi_pkg::OP_CAPTURE:
            begin
                rx_next   = rate_x;
                ry_next   = rate_y;
                rz_next   = rate_z;
                c_next[0] = 64'($signed(load_w));
                c_next[1] = 64'($signed(load_x));
                c_next[2] = 64'($signed(load_y));
                c_next[3] = 64'($signed(load_z));
            end
            aqi_pkg::OP_MUL_RSQ, aqi_pkg::OP_MUL_H, aqi_pkg::OP_MUL_RY,
            aqi_pkg::OP_QMUL, aqi_pkg::OP_MUL_SSQ:
                prod_next = prod_full[63:0];
            aqi_pkg::OP_ACC:
                sum_next = (sel == 2'd0) ? 64'(prod_reg) : sum_reg + 64'(prod_reg);
            aqi_pkg::OP_SQRT_INIT:
            begin
                sx_next   = sum_reg;
                root_next = '0;
            end
            aqi_pkg::OP_SQRT_STEP:
            begin
                if (sx_reg >= sq_t)
                begin
                    sx_next   = sx_reg - sq_t;
                    root_next = (root_reg >> 1) + sq_b;
                end
                else
                    root_next = root_reg >> 1;
            end
            aqi_pkg::OP_H_SET:
            begin
                flip_next = (h_sat > aqi_pkg::HALF_PI_Q30);
                cx_next   = aqi_pkg::CORDIC_GAIN;
                cy_next   = '0;
                cz_next   = $signed({2'b00, h_fin});
            end
            aqi_pkg::OP_CORDIC:
            begin
                if (!cz_reg[33])
                begin
                    cx_next = cx_reg - cdx;
                    cy_next = cy_reg + cdy;
                    cz_next = cz_reg - cat;
                end
                else
                begin
                    cx_next = cx_reg + cdx;
                    cy_next = cy_reg - cdy;
                    cz_next = cz_reg + cat;
                end
            end
            aqi_pkg::OP_D0:
                d_next[0] = flip_reg ? -cx_reg : cx_reg;
            aqi_pkg::OP_D_IDENT:
            begin
                d_next[0] = $signed({2'b00, aqi_pkg::ONE_Q30});
                d_next[1] = '0;
                d_next[2] = '0;
                d_next[3] = '0;
            end
            aqi_pkg::OP_DIV_INIT_R:
            begin
                neg_next = prod_reg[63];
                rem_next = {1'b0, prod_mag[63:32]};
                quo_next = prod_mag[31:0];
            end
            aqi_pkg::OP_NDIV_INIT:
            begin
                neg_next = s_sel[31];
                rem_next = {1'b0, nd_div[63:32]};
                quo_next = nd_div[31:0];
            end
            aqi_pkg::OP_DIV_STEP:
            begin
                if (div_sh >= div_d)
                begin
                    rem_next = div_sh - div_d;
                    quo_next = {quo_reg[30:0], 1'b1};
                end
                else
                begin
                    rem_next = div_sh;
                    quo_next = {quo_reg[30:0], 1'b0};
                end
            end
            aqi_pkg::OP_D_STORE:
                d_next[sel + 2'd1] = neg_reg ? -dq : dq;
            aqi_pkg::OP_QACC:
            begin
                if (aqi_pkg::qterm_neg(cmd.idx))
                    c_next[cmd.idx[3:2]] = acc_base - prod_reg;
                else
                    c_next[cmd.idx[3:2]] = acc_base + prod_reg;
            end
            aqi_pkg::OP_MAX:
            begin
                if (sel == 2'd0)
                begin
                    m_next   = c_mag;
                    rsh_next = '0;
                    lsh_next = '0;
                end
                else if (c_mag > m_reg)
                    m_next = c_mag;
            end
            aqi_pkg::OP_SHR:
            begin
                m_next   = m_reg >> 1;
                rsh_next = rsh_reg + 6'd1;
            end
            aqi_pkg::OP_SHL:
            begin
                m_next   = m_reg << 1;
                lsh_next = lsh_reg + 6'd1;
            end
            aqi_pkg::OP_SCALE:
                s_next[sel] = c_scaled[31:0];
            aqi_pkg::OP_IDENT:
            begin
                att_next[0] = aqi_pkg::ONE_Q30;
                att_next[1] = '0;
                att_next[2] = '0;
                att_next[3] = '0;
            end
            aqi_pkg::OP_NSTORE:
                att_next[sel] = neg_reg ? -$signed(q_clamp) : $signed(q_clamp);
            aqi_pkg::OP_OUT:
            begin
                for (int i = 0; i < 4; i++)
                    out_next[i] = att_reg[i];
            end
            default:
            begin
            end
        endcase
    end

    // attitude state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            att_reg[0] <= aqi_pkg::ONE_Q30;
            att_reg[1] <= '0;
            att_reg[2] <= '0;
            att_reg[3] <= '0;
        end
        else
        begin
            for (int i = 0; i < 4; i++)
                att_reg[i] <= att_next[i];
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        rx_reg   <= rx_next;
        ry_reg   <= ry_next;
        rz_reg   <= rz_next;
        prod_reg <= prod_next;
        sum_reg  <= sum_next;
        sx_reg   <= sx_next;
        root_reg <= root_next;
        flip_reg <= flip_next;
        cx_reg   <= cx_next;
        cy_reg   <= cy_next;
        cz_reg   <= cz_next;
        m_reg    <= m_next;
        rsh_reg  <= rsh_next;
        lsh_reg  <= lsh_next;
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        neg_reg  <= neg_next;
        for (int i = 0; i < 4; i++)
        begin
            d_reg[i]   <= d_next[i];
            c_reg[i]   <= c_next[i];
            s_reg[i]   <= s_next[i];
            out_reg[i] <= out_next[i];
        end
    end

    assign att_w = out_reg[0];
    assign att_x = out_reg[1];
    assign att_y = out_reg[2];
    assign att_z = out_reg[3];

endmodule

`default_nettype wire

// File: src/attitude_quaternion_integrator_core.sv
// Top level of the attitude quaternion integrator: stream ports, APB register.
// Depends on aqi_pkg, aqi_ctrl and aqi_dp.
//
//   channel   dir   transfer      payload
//   s_axis    in    tvalid/tready tuser command, tdata rates and load quaternion
//   m_axis    out   tvalid/tready tdata new attitude w, x, y, z
//   apb       in    psel/penable  time_step at address 0
//
// A load runs up to 29 normalize shifts, the 32-step root and four 32-step one-bit
// divides; a zero quaternion becomes identity. A propagate runs up to 33 shifts, the
// 32-step root twice, the rotation steps and seven divides (four at zero rate).
// One item is worked at a time; the result register lets the next item enter
// while the result waits, a finished item stalls until it is taken. Reset: identity.
`default_nettype none

module attitude_quaternion_integrator_core #(
    parameter int CORDIC_ITERATIONS = aqi_pkg::CORDIC_ITERATIONS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // tdata: rate_x, rate_y, rate_z, load_w, load_x, load_y, load_z
    input  logic [223:0] s_axis_tdata,
    // tuser: command
    input  logic         s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // tdata: att_w, att_x, att_y, att_z
    output logic [127:0] m_axis_tdata,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    aqi_pkg::cmd_t cmd;
    aqi_pkg::sts_t sts;
    logic [31:0]   time_step_reg, time_step_next;

    // configuration register
    assign pready = 1'b1;

    always_comb
    begin
        time_step_next = time_step_reg;
        if (psel && penable && pwrite && (paddr[2] == aqi_pkg::REG_TIME_STEP))
            time_step_next = pwdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            time_step_reg <= aqi_pkg::TIME_STEP_RESET;
        else
            time_step_reg <= time_step_next;
    end

    assign prdata = (paddr[2] == aqi_pkg::REG_TIME_STEP) ? time_step_reg : '0;

    aqi_ctrl #(
        .CORDIC_ITERATIONS(CORDIC_ITERATIONS)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .cmd           (cmd),
        .sts           (sts)
    );

    aqi_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .time_step (time_step_reg),
        .rate_x    (s_axis_tdata[31:0]),
        .rate_y    (s_axis_tdata[63:32]),
        .rate_z    (s_axis_tdata[95:64]),
        .load_w    (s_axis_tdata[127:96]),
        .load_x    (s_axis_tdata[159:128]),
        .load_y    (s_axis_tdata[191:160]),
        .load_z    (s_axis_tdata[223:192]),
        .att_w     (m_axis_tdata[31:0]),
        .att_x     (m_axis_tdata[63:32]),
        .att_y     (m_axis_tdata[95:64]),
        .att_z     (m_axis_tdata[127:96])
    );

endmodule

`default_nettype wire

// File: src/aqi_checker.sv
// Port checker for the attitude integrator, bound to the top level.
// Depends on attitude_quaternion_integrator_core_assert.svh.
`default_nettype none

`include "attitude_quaternion_integrator_core_assert.svh"

module aqi_checker (
    input logic         clk,
    input logic         rst_n,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [127:0] m_axis_tdata
);

    // a held result stays offered
    `AQI_ASSERT_NXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)

    // a held result keeps its data
    `AQI_ASSERT_NXT(a_out_stable, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata))

    // an accepted item keeps the block busy for the next cycle
    `AQI_ASSERT_NXT(a_busy_after_in, s_axis_tvalid && s_axis_tready, !s_axis_tready)

    // normalized scalar part within one
    `AQI_ASSERT_IMP(a_w_range, m_axis_tvalid,
        ($signed(m_axis_tdata[31:0]) <= 32'sd1073741824) &&
        ($signed(m_axis_tdata[31:0]) >= -32'sd1073741824))

    // normalized z part within one
    `AQI_ASSERT_IMP(a_z_range, m_axis_tvalid,
        ($signed(m_axis_tdata[127:96]) <= 32'sd1073741824) &&
        ($signed(m_axis_tdata[127:96]) >= -32'sd1073741824))

endmodule

bind attitude_quaternion_integrator_core aqi_checker u_aqi_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
